// ----- design/bcp_pkg.sv -----
// Shared types and constants for the box center in polygon test.
// Holds the channel words, the vertex and point types, the edge unit
// control and status structs, and the sequencer state type.
`default_nettype none

package bcp_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_W      = 16;
  localparam int DIM_W        = 15;
  localparam int VIDX_W       = 5;
  localparam int CNT_W        = 6;
  localparam int K_W          = $clog2(MAX_VERTICES + 1);
  localparam int PT_W         = COORD_W + 1;
  localparam int DIFF_W       = PT_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int D_W          = PROD_W + 1;
  localparam int MIN_VERTICES = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [VIDX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [DIM_W-1:0]          box_w;
    logic [DIM_W-1:0]          box_h;
  } in_word_t;

  typedef struct packed {
    logic is_test;
    logic inside_res;
    logic on_edge;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } edge_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
    logic odd;
  } edge_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- design/bcp_vertex_cell.sv -----
// One vertex cell of the rotating vertex ring.
// Loads a vertex on a write, or takes its neighbor's vertex on a shift.
// Depends on bcp_pkg.
`default_nettype none

module bcp_vertex_cell (
  input  wire logic            clk_i,
  input  wire logic            load_i,
  input  wire logic            shift_i,
  input  wire bcp_pkg::vertex_t load_data_i,
  input  wire bcp_pkg::vertex_t next_data_i,
  output bcp_pkg::vertex_t     data_o
);

  bcp_pkg::vertex_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_data_i;
    end
  end

  // Vertex storage is undefined until written, so no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- design/bcp_edge_unit.sv -----
// Pipelined edge evaluator: one polygon edge per cycle, crossing parity
// and on-edge flag accumulated over the scan. Depends on bcp_pkg.
`default_nettype none

module bcp_edge_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcp_pkg::edge_ctl_t ctl_i,
  input  wire bcp_pkg::vertex_t   a_i,
  input  wire bcp_pkg::vertex_t   b_i,
  input  wire bcp_pkg::point_t    p_i,
  output bcp_pkg::edge_sts_t      sts_o
);

  logic signed [bcp_pkg::PT_W-1:0]   ax, ay, bx, by, px, py;
  logic                              skip, skip_hit;
  logic signed [bcp_pkg::DIFF_W-1:0] dy1, dx1, dx2, dy2;

  // Stage 1: compares and differences.
  logic                              v1_q;
  logic                              skip1_q, skhit1_q, dir1_q;
  logic signed [bcp_pkg::DIFF_W-1:0] dy1_q, dx1_q, dx2_q, dy2_q;

  // Stage 2: cross products.
  logic                              v2_q;
  logic                              skip2_q, skhit2_q, dir2_q;
  logic signed [bcp_pkg::PROD_W-1:0] prod1_q, prod2_q;

  logic signed [bcp_pkg::D_W-1:0]    d;
  logic                              crossing;
  logic                              hit_q, hit_d, odd_q, odd_d;

  assign ax = bcp_pkg::PT_W'($signed(a_i.x));
  assign ay = bcp_pkg::PT_W'($signed(a_i.y));
  assign bx = bcp_pkg::PT_W'($signed(b_i.x));
  assign by = bcp_pkg::PT_W'($signed(b_i.y));
  assign px = p_i.x;
  assign py = p_i.y;

  always_comb begin
    skip = (ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px);
    // Edge not straddling the scan line: still a hit on its end vertex or
    // when the point lies on a horizontal edge.
    skip_hit = (py == by) && ((px == bx) ||
               ((py == ay) && ((ax <= px && px <= bx) || (bx <= px && px <= ax))));
    dy1 = bcp_pkg::DIFF_W'(py) - bcp_pkg::DIFF_W'(ay);
    dx1 = bcp_pkg::DIFF_W'(bx) - bcp_pkg::DIFF_W'(ax);
    dx2 = bcp_pkg::DIFF_W'(px) - bcp_pkg::DIFF_W'(ax);
    dy2 = bcp_pkg::DIFF_W'(by) - bcp_pkg::DIFF_W'(ay);
  end

  always_ff @(posedge clk_i) begin
    skip1_q  <= skip;
    skhit1_q <= skip_hit;
    dir1_q   <= (by < ay);
    dy1_q    <= dy1;
    dx1_q    <= dx1;
    dx2_q    <= dx2;
    dy2_q    <= dy2;
    skip2_q  <= skip1_q;
    skhit2_q <= skhit1_q;
    dir2_q   <= dir1_q;
    prod1_q  <= dy1_q * dx1_q;
    prod2_q  <= dx2_q * dy2_q;
  end

  always_comb begin
    d        = bcp_pkg::D_W'(prod1_q) - bcp_pkg::D_W'(prod2_q);
    crossing = dir2_q ? d[bcp_pkg::D_W-1] : (!d[bcp_pkg::D_W-1] && (d != '0));
    hit_d    = hit_q;
    odd_d    = odd_q;
    if (ctl_i.clear) begin
      hit_d = 1'b0;
      odd_d = 1'b0;
    end else if (v2_q) begin
      if (skip2_q) begin
        hit_d = hit_q | skhit2_q;
      end else if (d == '0) begin
        hit_d = 1'b1;
      end else begin
        odd_d = odd_q ^ crossing;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      hit_q <= 1'b0;
      odd_q <= 1'b0;
    end else begin
      v1_q  <= ctl_i.valid;
      v2_q  <= v1_q;
      hit_q <= hit_d;
      odd_q <= odd_d;
    end
  end

  assign sts_o.busy = v1_q | v2_q;
  assign sts_o.hit  = hit_q;
  assign sts_o.odd  = odd_q;

`ifndef SYNTHESIS
  a_v2_follows_v1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("edge stage 2 valid without stage 1");
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (!hit_q && !odd_q)) else $error("accumulators not cleared");
  a_no_clear_midscan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |-> !(v1_q || v2_q)) else $error("clear while edges in flight");
`endif

endmodule

`default_nettype wire

// ----- design/box_center_in_polygon_test_top.sv -----
// Top level of the box center in polygon test: vertex ring, sequencer,
// edge unit and output register. Depends on bcp_pkg, bcp_vertex_cell and
// bcp_edge_unit.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+----------------------
//   input    | in        | in_valid_i / in_stall_o | bcp_pkg::in_word_t
//   output   | out       | out_valid_o / out_stall_i | bcp_pkg::out_word_t
//   config   | in        | cfg_valid_i / cfg_ready_o | vertex_count, 6 bits
//
// A vertex write, or a test with fewer than 3 vertices, goes straight to ST_DONE
// and loads its word into the output register. Otherwise the vertex ring rotates
// through MAX_VERTICES + 1 steps, one edge per cycle into the two-stage edge unit,
// then drains in ST_DRAIN until the edge unit is idle and loads in ST_DONE.
// in_stall_o is high from accept until the load; a load waits while out_stall_i
// holds the previous word. Reset clears control state; vertex cells are undefined.
`default_nettype none

module box_center_in_polygon_test_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bcp_pkg::in_word_t   in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bcp_pkg::out_word_t       out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [bcp_pkg::CNT_W-1:0] cfg_data_i
);

  bcp_pkg::state_e     state_q, state_d;
  logic [bcp_pkg::CNT_W-1:0] count_q;
  logic [bcp_pkg::K_W-1:0]   n_eff, n_q, k_q, k_d;
  bcp_pkg::point_t     p_q, p_d;
  bcp_pkg::vertex_t    prev_q, first_q, edge_b;
  logic                is_test_q;
  logic                accept, shift_en, out_load;
  logic                out_valid_q;
  bcp_pkg::out_word_t  out_q;
  bcp_pkg::edge_ctl_t  ectl;
  bcp_pkg::edge_sts_t  ests;
  bcp_pkg::vertex_t    ring [bcp_pkg::MAX_VERTICES];
  bcp_pkg::vertex_t    wr_vertex;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign n_eff       = (int'(count_q) > bcp_pkg::MAX_VERTICES) ?
                       bcp_pkg::K_W'(bcp_pkg::MAX_VERTICES) : bcp_pkg::K_W'(count_q);
  assign wr_vertex.x = in_word_i.vertex_x;
  assign wr_vertex.y = in_word_i.vertex_y;

  // Vertex ring: cell i takes cell i+1, so vertex k reaches cell 0 at step k.
  for (genvar i = 0; i < bcp_pkg::MAX_VERTICES; i++) begin : g_cell
    bcp_vertex_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (accept && (in_word_i.cmd == bcp_pkg::CMD_WRITE) &&
                    (int'(in_word_i.vertex_index) == i)),
      .shift_i     (shift_en),
      .load_data_i (wr_vertex),
      .next_data_i (ring[(i + 1) % bcp_pkg::MAX_VERTICES]),
      .data_o      (ring[i])
    );
  end

  // Closing edge runs from the last vertex back to vertex 0.
  assign edge_b = (k_q == n_q) ? first_q : ring[0];

  bcp_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ectl),
    .a_i    (prev_q),
    .b_i    (edge_b),
    .p_i    (p_q),
    .sts_o  (ests)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcp_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_word_i.cmd == bcp_pkg::CMD_TEST) &&
              (int'(n_eff) >= bcp_pkg::MIN_VERTICES)) begin
            state_d = bcp_pkg::ST_RUN;
          end else begin
            state_d = bcp_pkg::ST_DONE;
          end
        end
      end
      bcp_pkg::ST_RUN: begin
        if (int'(k_q) == bcp_pkg::MAX_VERTICES) begin
          state_d = bcp_pkg::ST_DRAIN;
        end
      end
      bcp_pkg::ST_DRAIN: begin
        if (!ests.busy) begin
          state_d = bcp_pkg::ST_DONE;
        end
      end
      bcp_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = bcp_pkg::ST_IDLE;
        end
      end
      default: state_d = bcp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o  = (state_q != bcp_pkg::ST_IDLE);
    shift_en    = (state_q == bcp_pkg::ST_RUN) && (int'(k_q) < bcp_pkg::MAX_VERTICES);
    ectl.valid  = (state_q == bcp_pkg::ST_RUN) && (k_q != '0) && (k_q <= n_q);
    ectl.clear  = accept;
    out_load    = (state_q == bcp_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    k_d = k_q;
    if (accept) begin
      k_d = '0;
    end else if (state_q == bcp_pkg::ST_RUN) begin
      k_d = k_q + 1'b1;
    end
    p_d.x = bcp_pkg::PT_W'(in_word_i.box_x) +
            bcp_pkg::PT_W'(in_word_i.box_w[bcp_pkg::DIM_W-1:1]);
    p_d.y = bcp_pkg::PT_W'(in_word_i.box_y) +
            bcp_pkg::PT_W'(in_word_i.box_h[bcp_pkg::DIM_W-1:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcp_pkg::ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q       <= p_d;
      n_q       <= n_eff;
      is_test_q <= (in_word_i.cmd == bcp_pkg::CMD_TEST);
    end
    if (state_q == bcp_pkg::ST_RUN) begin
      prev_q <= ring[0];
      if (k_q == '0) begin
        first_q <= ring[0];
      end
    end
    if (out_load) begin
      out_q.is_test    <= is_test_q;
      out_q.inside_res <= ests.hit | ests.odd;
      out_q.on_edge    <= ests.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcp_pkg::ST_RUN && int'(k_q) == bcp_pkg::MAX_VERTICES)
    |=> (state_q == bcp_pkg::ST_DRAIN)) else $error("ring scan did not end");
  a_edge_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcp_pkg::ST_IDLE) |-> !ests.busy) else $error("edge unit busy in idle");
  a_on_edge_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_word_o.on_edge || out_word_o.inside_res))
    else $error("on_edge without inside_res");
  a_ack_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.is_test) |-> (!out_word_o.inside_res && !out_word_o.on_edge))
    else $error("write acknowledge carries a test result");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_box_center_in_polygon_test_top.sv -----
// Self-checking testbench for box_center_in_polygon_test_top.
// Predicts each result word from its own copy of the vertex table and count
// register; depends only on bcp_pkg and the top level.
module tb_box_center_in_polygon_test_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcp_pkg::*;

  typedef enum logic [1:0] {
    PT_OUTSIDE,
    PT_INSIDE,
    PT_ON_EDGE
  } pt_class_e;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_BURSTY,
    RX_TOGGLE
  } rx_mode_e;

  localparam int COORD_MIN     = -32768;
  localparam int COORD_MAX     = 32767;
  localparam int DIM_MAX       = 32767;
  localparam int FULL_SPAN     = COORD_MAX + 1;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = MAX_VERTICES + 8;
  localparam int NO_GAP_BURST  = 1000000000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_word_t           in_word_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CNT_W-1:0]   cfg_data_i  = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_word_t          out_word_o;
  logic               cfg_ready_o;

  box_center_in_polygon_test_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: vertex table and count register as the block holds them.
  vertex_t   poly_ring [MAX_VERTICES];
  int        vertex_count_q = 0;
  out_word_t result_q [$];

  int       err_cnt    = 0;
  int       items_sent = 0;
  int       burst_left = NO_GAP_BURST;
  bit       bursty_tx  = 1'b0;
  rx_mode_e rx_mode    = RX_FREE;
  int       rx_cycle   = 0;
  int       rx_run     = 0;
  logic     rx_hold    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("box_center_in_polygon_test_top verification failed");
    $finish;
  end

  // Even-odd crossing test; the first edge containing the point ends the scan.
  function automatic pt_class_e classify_center(input longint px, input longint py,
                                                input int n);
    longint ax, ay, bx, by, d;
    int crossings;
    crossings = 0;
    bx = poly_ring[n-1].x;
    by = poly_ring[n-1].y;
    for (int i = 0; i < n; i++) begin
      ax = bx;
      ay = by;
      bx = poly_ring[i].x;
      by = poly_ring[i].y;
      if ((ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px)) begin
        if (py == by && (px == bx ||
            (py == ay && ((ax <= px && px <= bx) || (bx <= px && px <= ax)))))
          return PT_ON_EDGE;
        continue;
      end
      d = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
      if (d == 0)
        return PT_ON_EDGE;
      if (by < ay)
        d = -d;
      if (d > 0)
        crossings++;
    end
    return crossings[0] ? PT_INSIDE : PT_OUTSIDE;
  endfunction

  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t r;
    longint    cx, cy;
    int        n;
    pt_class_e c;
    r = '0;
    if (w.cmd == CMD_WRITE) begin
      poly_ring[w.vertex_index].x = w.vertex_x;
      poly_ring[w.vertex_index].y = w.vertex_y;
      return r;
    end
    r.is_test = 1'b1;
    n = (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : vertex_count_q;
    if (n < MIN_VERTICES)
      return r;
    cx = longint'(w.box_x) + longint'(w.box_w / 2);
    cy = longint'(w.box_y) + longint'(w.box_h / 2);
    c = classify_center(cx, cy, n);
    r.inside_res = (c != PT_OUTSIDE);
    r.on_edge    = (c == PT_ON_EDGE);
    return r;
  endfunction

  // Receiver: check each accepted word and drive stall in shifting patterns.
  always @(posedge clk_i) begin : rx_side
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("result word %b with nothing pending", out_word_o);
        err_cnt++;
      end else begin
        exp_w = result_q.pop_front();
        if (out_word_o.is_test !== exp_w.is_test) begin
          $error("is_test: expected %0b, got %0b", exp_w.is_test, out_word_o.is_test);
          err_cnt++;
        end
        if (out_word_o.inside_res !== exp_w.inside_res) begin
          $error("inside_res: expected %0b, got %0b", exp_w.inside_res,
                 out_word_o.inside_res);
          err_cnt++;
        end
        if (out_word_o.on_edge !== exp_w.on_edge) begin
          $error("on_edge: expected %0b, got %0b", exp_w.on_edge, out_word_o.on_edge);
          err_cnt++;
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 300 == 0)
      rx_mode = rx_mode_e'(2'($urandom_range(0, 3)));
    case (rx_mode)
      RX_FREE:   out_stall_i <= 1'b0;
      RX_SPARSE: out_stall_i <= ($urandom_range(0, 4) == 0);
      RX_BURSTY: begin
        if (rx_run == 0) begin
          rx_run  = $urandom_range(1, 12);
          rx_hold = ~rx_hold;
        end
        rx_run--;
        out_stall_i <= rx_hold;
      end
      default:   out_stall_i <= ~out_stall_i;
    endcase
  end

  function automatic in_word_t rand_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return in_word_t'(raw[$bits(in_word_t)-1:0]);
  endfunction

  function automatic int rand_coord(input int span);
    if (span >= FULL_SPAN)
      return int'($signed(16'($urandom)));
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic set_tx_mode(input bit bursty);
    bursty_tx  = bursty;
    burst_left = bursty ? $urandom_range(1, 12) : NO_GAP_BURST;
  endtask

  // Send one word; hold it until accepted, then queue its prediction.
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = bursty_tx ? $urandom_range(1, 12) : NO_GAP_BURST;
    end
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    result_q = {result_q, predict_result(w)};
    items_sent++;
    burst_left--;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input int n);
    settle();
    cfg_data_i  <= CNT_W'(n);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    vertex_count_q = n;
  endtask

  task automatic send_vertex(input int idx, input int x, input int y);
    in_word_t w;
    w = rand_word();
    w.cmd          = CMD_WRITE;
    w.vertex_index = VIDX_W'(idx);
    w.vertex_x     = COORD_W'(x);
    w.vertex_y     = COORD_W'(y);
    send_word(w);
  endtask

  task automatic send_box(input int bx, input int by, input int bw, input int bh);
    in_word_t w;
    w = rand_word();
    w.cmd   = CMD_TEST;
    w.box_x = COORD_W'(bx);
    w.box_y = COORD_W'(by);
    w.box_w = DIM_W'(bw);
    w.box_h = DIM_W'(bh);
    send_word(w);
  endtask

  // Pick a random box whose truncated center lands on the given point, clamped into range.
  task automatic send_test_at(input int tx, input int ty);
    int cx, cy, mx, my, bw, bh;
    cx = (tx < COORD_MIN) ? COORD_MIN : (tx > COORD_MAX) ? COORD_MAX : tx;
    cy = (ty < COORD_MIN) ? COORD_MIN : (ty > COORD_MAX) ? COORD_MAX : ty;
    mx = 2 * (cx - COORD_MIN) + 1;
    my = 2 * (cy - COORD_MIN) + 1;
    bw = $urandom_range(0, (mx > DIM_MAX) ? DIM_MAX : mx);
    bh = $urandom_range(0, (my > DIM_MAX) ? DIM_MAX : my);
    send_box(cx - bw / 2, cy - bh / 2, bw, bh);
  endtask

  task automatic test_random_point(input int n);
    int sel, i, j, ax, ay, dx, dy, g, r, t, k, lo_x, hi_x, lo_y, hi_y;
    sel = $urandom_range(0, 9);
    i   = $urandom_range(0, n - 1);
    ax  = poly_ring[i].x;
    ay  = poly_ring[i].y;
    if (sel < 3) begin
      send_test_at(ax, ay);
    end else if (sel < 5) begin
      // lattice point on the edge from vertex i to the next one
      j  = (i + 1) % n;
      dx = poly_ring[j].x - ax;
      dy = poly_ring[j].y - ay;
      g  = (dx < 0) ? -dx : dx;
      r  = (dy < 0) ? -dy : dy;
      while (r != 0) begin
        t = g % r;
        g = r;
        r = t;
      end
      if (g == 0)
        g = 1;
      k = $urandom_range(0, g);
      send_test_at(ax + k * (dx / g), ay + k * (dy / g));
    end else if (sel == 5) begin
      send_test_at(ax + int'($urandom_range(0, 2)) - 1, ay + int'($urandom_range(0, 2)) - 1);
    end else if (sel < 8) begin
      lo_x = COORD_MAX; hi_x = COORD_MIN; lo_y = COORD_MAX; hi_y = COORD_MIN;
      for (int v = 0; v < n; v++) begin
        if (poly_ring[v].x < lo_x) lo_x = poly_ring[v].x;
        if (poly_ring[v].x > hi_x) hi_x = poly_ring[v].x;
        if (poly_ring[v].y < lo_y) lo_y = poly_ring[v].y;
        if (poly_ring[v].y > hi_y) hi_y = poly_ring[v].y;
      end
      send_test_at(lo_x + int'($urandom_range(0, hi_x - lo_x)),
                   lo_y + int'($urandom_range(0, hi_y - lo_y)));
    end else begin
      send_box(rand_coord(FULL_SPAN), rand_coord(FULL_SPAN),
               $urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX));
    end
  endtask

  // Fewer than three vertices: always outside, even on a vertex.
  task automatic test_too_few_vertices();
    set_tx_mode(1'b1);
    set_vertex_count(0);
    send_box(COORD_MIN, COORD_MIN, DIM_MAX, DIM_MAX);
    set_vertex_count(2);
    send_vertex(0, 10, 10);
    send_vertex(1, 20, 20);
    send_test_at(10, 10);
    set_vertex_count(1);
    send_test_at(20, 20);
  endtask

  task automatic test_square_cases();
    set_tx_mode(1'b0);
    set_vertex_count(4);
    send_vertex(0, 0, 0);
    send_vertex(1, 100, 0);
    send_vertex(2, 100, 100);
    send_vertex(3, 0, 100);
    send_test_at(50, 50);
    send_test_at(200, 50);
    send_test_at(100, 100);
    send_test_at(50, 0);
    send_test_at(0, 50);
    send_test_at(-10, 100);
    send_test_at(50, 100);
  endtask

  // Corner-to-corner triangle: coordinate extremes and a diagonal edge.
  task automatic test_coordinate_extremes();
    set_tx_mode(1'b1);
    set_vertex_count(3);
    send_vertex(0, COORD_MIN, COORD_MIN);
    send_vertex(1, COORD_MAX, COORD_MIN);
    send_vertex(2, COORD_MAX, COORD_MAX);
    send_box(COORD_MAX, COORD_MAX, DIM_MAX, DIM_MAX);
    send_box(COORD_MIN, COORD_MIN, 0, 0);
    send_test_at(0, 0);
    send_test_at(100, -50);
  endtask

  task automatic test_random_polygons();
    int stop_at, cnt, n_eff, n_pick, span;
    stop_at = items_sent + RANDOM_ITEMS;
    set_tx_mode(1'b1);
    // fill every slot once so any count reads written vertices only
    for (int i = 0; i < MAX_VERTICES; i++)
      send_vertex(i, rand_coord(FULL_SPAN), rand_coord(FULL_SPAN));
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       cnt = $urandom_range(0, MIN_VERTICES - 1);
        1:       cnt = MAX_VERTICES;
        2:       cnt = $urandom_range(0, 1) ? 63 : $urandom_range(MAX_VERTICES + 1, 62);
        3:       cnt = MIN_VERTICES;
        default: cnt = $urandom_range(MIN_VERTICES + 1, 12);
      endcase
      case ($urandom_range(0, 2))
        0:       span = 64;
        1:       span = 2000;
        default: span = FULL_SPAN;
      endcase
      set_vertex_count(cnt);
      set_tx_mode($urandom_range(0, 2) != 0);
      n_eff  = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
      n_pick = (n_eff < MIN_VERTICES) ? MAX_VERTICES : n_eff;
      for (int i = 0; i < n_eff; i++)
        send_vertex(i, rand_coord(span), rand_coord(span));
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex($urandom_range(0, MAX_VERTICES - 1), rand_coord(span), rand_coord(span));
        test_random_point(n_pick);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_VERTICES; i++)
      poly_ring[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_too_few_vertices();
    test_square_cases();
    test_coordinate_extremes();
    test_random_polygons();
    settle();
    if (err_cnt == 0)
      $display("box_center_in_polygon_test_top verification clean");
    else
      $display("box_center_in_polygon_test_top verification failed");
    $finish;
  end

endmodule
